[rtl/pawc_pkg.sv]
// ----------------------------------------------------------------------------
// pawc_pkg
// Shared types and constants of the PID controller with anti-windup.
// ----------------------------------------------------------------------------
package pawc_pkg;

    typedef enum logic [2:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_LIMIT_LO = 3'd3,
        REG_LIMIT_HI = 3'd4,
        REG_PERIOD   = 3'd5
    } cfg_reg_t;

    // milliseconds per second
    localparam logic [9:0]  DT_SCALE   = 10'd1000;
    localparam int          DIV_STEPS  = 64;
    localparam int          RCP_STEPS  = 4;
    localparam int          CNT_WIDTH  = 6;
    localparam logic [1:0]  TERM_LAST  = 2'd2;
    // floor(2^64 / 1000), reciprocal of the millisecond scale
    localparam logic [63:0] RCP_1000   = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000;

    typedef struct packed {
        logic latch;
        logic load;
        logic mul_i;
        logic set_i;
        logic rcp_step;
        logic div_step;
        logic end_i;
        logic set_d;
        logic end_d;
        logic term_load;
        logic term_lo;
        logic term_hi;
        logic term_acc;
        logic finish;
    } pawc_cmd_t;

    typedef struct packed {
        logic enabled;
        logic dt_zero;
        logic div_last;
        logic term_last;
        logic out_free;
    } pawc_status_t;

endpackage

[rtl/pid_anti_windup_controller_unit.sv]
// ----------------------------------------------------------------------------
// pid_anti_windup_controller_unit
// PID controller, Q16.16, conditional-integration anti-windup.
//
//   channel  direction  handshake          payload
//   cfg      in         cfg_valid/ready    cfg_index, cfg_data
//   s        in         s_tvalid/tready    s_tdata (scan)
//   m        out        m_tvalid/tready    m_tdata (drive), m_tuser (frozen)
//
// An enabled scan's time from accept to result is set by the 64-step radix-2
// derivative division, which a zero step time skips; a disabled scan goes from
// load straight to finish. The integral scaling by 1/1000 takes four multiplier passes and a fix-up.
// One scan at a time; the next beat is taken while a result waits.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled output holds the sequencer at its last step only.
// ----------------------------------------------------------------------------
module pid_anti_windup_controller_unit
    import pawc_pkg::*;
#(
    parameter int FRACTION_BITS  = 16,
    parameter int INTEGRAL_WIDTH = 48
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // enable_level[31:0], process_value[63:32], setpoint[95:64], timestamp_ms[127:96]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // drive_value[31:0]
    output logic [31:0]  m_tdata,
    // integral_frozen[0]
    output logic [0:0]   m_tuser
);

    pawc_cmd_t    cmd;
    pawc_status_t status;

    assign cfg_ready = 1'b1;

    pawc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    pawc_datapath #(
        .FRACTION_BITS  (FRACTION_BITS),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[rtl/pawc_ctrl.sv]
// ----------------------------------------------------------------------------
// pawc_ctrl
// Sequencer of one control scan: error, integral scaling by reciprocal,
// derivative division, three gain products, clamp and write-back.
// ----------------------------------------------------------------------------
module pawc_ctrl
    import pawc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    output pawc_cmd_t    cmd,
    input  pawc_status_t status
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_LOAD   = 14'b00000000000010,
        S_MUL_I  = 14'b00000000000100,
        S_SET_I  = 14'b00000000001000,
        S_RCP_I  = 14'b00000000010000,
        S_END_I  = 14'b00000000100000,
        S_SET_D  = 14'b00000001000000,
        S_DIV_D  = 14'b00000010000000,
        S_END_D  = 14'b00000100000000,
        S_T_LOAD = 14'b00001000000000,
        S_T_LO   = 14'b00010000000000,
        S_T_HI   = 14'b00100000000000,
        S_T_ACC  = 14'b01000000000000,
        S_FINISH = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = status.enabled ? S_MUL_I : S_FINISH;
            end
            S_MUL_I:
            begin
                cmd.mul_i  = 1'b1;
                state_next = S_SET_I;
            end
            S_SET_I:
            begin
                cmd.set_i  = 1'b1;
                state_next = S_RCP_I;
            end
            S_RCP_I:
            begin
                cmd.rcp_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_END_I;
                end
            end
            S_END_I:
            begin
                cmd.end_i  = 1'b1;
                state_next = S_SET_D;
            end
            S_SET_D:
            begin
                cmd.set_d  = 1'b1;
                // zero step time: derivative stays zero, skip the division
                state_next = status.dt_zero ? S_T_LOAD : S_DIV_D;
            end
            S_DIV_D:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_END_D;
                end
            end
            S_END_D:
            begin
                cmd.end_d  = 1'b1;
                state_next = S_T_LOAD;
            end
            S_T_LOAD:
            begin
                cmd.term_load = 1'b1;
                state_next    = S_T_LO;
            end
            S_T_LO:
            begin
                cmd.term_lo = 1'b1;
                state_next  = S_T_HI;
            end
            S_T_HI:
            begin
                cmd.term_hi = 1'b1;
                state_next  = S_T_ACC;
            end
            S_T_ACC:
            begin
                cmd.term_acc = 1'b1;
                state_next   = status.term_last ? S_FINISH : S_T_LOAD;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/pawc_datapath.sv]
// ----------------------------------------------------------------------------
// pawc_datapath
// Registers, shared 32x32 multiplier, radix-2 divider and output register of
// the PID controller.
// ----------------------------------------------------------------------------
module pawc_datapath
    import pawc_pkg::*;
#(
    parameter int FRACTION_BITS  = 16,
    parameter int INTEGRAL_WIDTH = 48
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,
    output logic [0:0]   m_tuser,
    input  pawc_cmd_t    cmd,
    output pawc_status_t status
);

    localparam int IW = INTEGRAL_WIDTH;
    localparam logic signed [31:0] EnableHalf = 32'sd1 <<< (FRACTION_BITS - 1);
    localparam logic signed [65:0] IntMax = (66'sd1 <<< (IW - 1)) - 66'sd1;
    localparam logic signed [65:0] IntMin = -IntMax - 66'sd1;
    localparam logic [63:0] PhiLimit = 64'd1 << (31 + FRACTION_BITS);
    localparam logic [64:0] MagLimit = 65'd1 << 63;
    localparam logic signed [63:0] S64Max = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64Min = {1'b1, {63{1'b0}}};

    // configuration
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [31:0] limit_lo_reg, limit_hi_reg;
    logic [15:0]        period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            limit_lo_reg <= '0;
            limit_hi_reg <= 32'sd6553600;
            period_reg   <= 16'd50;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:   gain_p_reg   <= cfg_data;
                REG_GAIN_I:   gain_i_reg   <= cfg_data;
                REG_GAIN_D:   gain_d_reg   <= cfg_data;
                REG_LIMIT_LO: limit_lo_reg <= cfg_data;
                REG_LIMIT_HI: limit_hi_reg <= cfg_data;
                REG_PERIOD:   period_reg   <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // scan beat
    logic signed [31:0] enable_reg, pv_reg, sp_reg;
    logic [31:0]        ts_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            enable_reg <= s_tdata[31:0];
            pv_reg     <= s_tdata[63:32];
            sp_reg     <= s_tdata[95:64];
            ts_reg     <= s_tdata[127:96];
        end
    end

    // controller state
    logic signed [IW-1:0] integral_reg;
    logic signed [31:0]   prev_err_reg;
    logic [31:0]          last_run_reg;

    // working registers
    logic signed [31:0]   err_reg;
    logic [31:0]          dt_reg;
    logic signed [IW-1:0] tent_reg;
    logic signed [31:0]   deriv_reg;
    logic signed [63:0]   sum_reg;
    logic [63:0]          prod_reg, plo_reg, mag_reg;
    logic [31:0]          ug_reg;
    logic                 neg_reg;
    logic [1:0]           term_idx_reg;
    logic [63:0]          dvd_reg;
    logic [31:0]          dvs_reg, rem_reg;
    logic                 div_neg_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [65:0]          rcp_acc_reg;

    logic                 out_valid_reg;
    logic [31:0]          drive_reg;
    logic                 frozen_reg;

    // error and step time
    logic signed [32:0] err_wide;
    logic signed [31:0] err_sat;
    logic [31:0]        dt_calc;
    logic [31:0]        err_mag;

    assign err_wide = {sp_reg[31], sp_reg} - {pv_reg[31], pv_reg};
    assign err_sat  = (err_wide[32] != err_wide[31])
                    ? (err_wide[32] ? 32'sh80000000 : 32'sh7FFFFFFF)
                    : err_wide[31:0];
    assign dt_calc  = (last_run_reg == '0) ? {16'd0, period_reg} : ts_reg - last_run_reg;
    assign err_mag  = err_reg[31] ? (32'd0 - err_reg) : err_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        priority if (cmd.mul_i)
        begin
            mul_a = err_mag;
            mul_b = dt_reg;
        end
        else if (cmd.rcp_step)
        begin
            // partial products of the dividend and the reciprocal, low halves first
            mul_a = cnt_reg[1] ? dvd_reg[31:0] : dvd_reg[63:32];
            mul_b = cnt_reg[0] ? RCP_1000[31:0] : RCP_1000[63:32];
        end
        else if (cmd.term_lo)
        begin
            mul_a = mag_reg[31:0];
            mul_b = ug_reg;
        end
        else if (cmd.term_hi)
        begin
            mul_a = mag_reg[63:32];
            mul_b = ug_reg;
        end
    end

    assign mul_p = mul_a * mul_b;

    // reciprocal quotient may fall one short; fix it from the remainder
    logic [63:0] rcp_q, rcp_back, rcp_rem, quot_fix;

    assign rcp_q    = rcp_acc_reg[63:0];
    assign rcp_back = (rcp_q << 10) - (rcp_q << 4) - (rcp_q << 3);
    assign rcp_rem  = dvd_reg - rcp_back;
    assign quot_fix = rcp_q + {63'd0, (rcp_rem >= {54'd0, DT_SCALE})};

    // derivative dividend
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [42:0]        diff_scaled;

    assign diff        = {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};
    assign diff_mag    = diff[32] ? (33'd0 - diff) : diff;
    assign diff_scaled = 43'(diff_mag) * 43'(DT_SCALE);

    // divider step
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, dvd_reg[63]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // integral increment and tentative integral
    logic signed [63:0] incr;
    logic signed [65:0] tent_wide;
    logic signed [65:0] tent_clamp;

    assign incr       = div_neg_reg ? (64'sd0 - $signed(dvd_reg)) : $signed(dvd_reg);
    assign tent_wide  = {{(66-IW){integral_reg[IW-1]}}, integral_reg}
                      + {{2{incr[63]}}, incr};
    assign tent_clamp = (tent_wide > IntMax) ? IntMax
                      : ((tent_wide < IntMin) ? IntMin : tent_wide);

    // derivative saturation
    logic signed [31:0] deriv_sat;

    always_comb
    begin
        if (div_neg_reg)
        begin
            deriv_sat = (dvd_reg > 64'h80000000) ? 32'sh80000000
                                                 : (32'd0 - dvd_reg[31:0]);
        end
        else
        begin
            deriv_sat = (dvd_reg > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : dvd_reg[31:0];
        end
    end

    // term operand select
    logic signed [63:0] term_a;
    logic signed [31:0] term_g;

    always_comb
    begin
        unique case (term_idx_reg)
            2'd0:
            begin
                term_a = {{32{err_reg[31]}}, err_reg};
                term_g = gain_p_reg;
            end
            2'd1:
            begin
                term_a = {{(64-IW){tent_reg[IW-1]}}, tent_reg};
                term_g = gain_i_reg;
            end
            default:
            begin
                term_a = {{32{deriv_reg[31]}}, deriv_reg};
                term_g = gain_d_reg;
            end
        endcase
    end

    // scaled product, saturating accumulate
    logic [64:0]        m_raw, m_sat;
    logic signed [63:0] term;
    logic signed [64:0] sum_wide;
    logic signed [63:0] sum_sat;

    assign m_raw = (prod_reg >= PhiLimit) ? MagLimit
                 : ({1'b0, prod_reg << (32 - FRACTION_BITS)}
                    + {1'b0, plo_reg >> FRACTION_BITS});
    assign m_sat = (m_raw > MagLimit) ? MagLimit : m_raw;

    always_comb
    begin
        if (m_sat == MagLimit)
        begin
            term = neg_reg ? S64Min : S64Max;
        end
        else
        begin
            term = neg_reg ? (64'sd0 - $signed(m_sat[63:0])) : $signed(m_sat[63:0]);
        end
    end

    assign sum_wide = {sum_reg[63], sum_reg} + {term[63], term};
    assign sum_sat  = (sum_wide[64] != sum_wide[63])
                    ? (sum_wide[64] ? S64Min : S64Max)
                    : sum_wide[63:0];

    // clamp and commit
    logic signed [63:0] up64, lo64;
    logic               above, below, commit;
    logic [31:0]        drive;

    assign up64   = {{32{limit_hi_reg[31]}}, limit_hi_reg};
    assign lo64   = {{32{limit_lo_reg[31]}}, limit_lo_reg};
    assign above  = (sum_reg > up64);
    assign below  = (sum_reg < lo64);
    assign commit = !above && !below;
    assign drive  = above ? limit_hi_reg : (below ? limit_lo_reg : sum_reg[31:0]);

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg <= err_sat;
            dt_reg  <= dt_calc;
            sum_reg <= '0;
        end
        if (cmd.mul_i || cmd.term_lo || cmd.term_hi)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.term_hi)
        begin
            plo_reg <= prod_reg;
        end
        if (cmd.rcp_step)
        begin
            unique case (cnt_reg[1:0])
                2'd3:    rcp_acc_reg <= {34'd0, mul_p[63:32]};
                2'd0:    rcp_acc_reg <= (rcp_acc_reg >> 32) + {2'd0, mul_p};
                default: rcp_acc_reg <= rcp_acc_reg + {2'd0, mul_p};
            endcase
        end
        if (cmd.set_i)
        begin
            dvd_reg     <= prod_reg;
            div_neg_reg <= err_reg[31];
        end
        else if (cmd.set_d)
        begin
            dvd_reg     <= 64'(diff_scaled);
            dvs_reg     <= dt_reg;
            rem_reg     <= '0;
            div_neg_reg <= diff[32];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            dvd_reg <= {dvd_reg[62:0], fits};
        end
        else if (cmd.end_i)
        begin
            dvd_reg <= quot_fix;
        end
        // increment still sits in the dividend register here
        if (cmd.set_d)
        begin
            tent_reg <= tent_clamp[IW-1:0];
        end
        if (cmd.set_d)
        begin
            deriv_reg <= '0;
        end
        else if (cmd.end_d)
        begin
            deriv_reg <= deriv_sat;
        end
        if (cmd.term_load)
        begin
            mag_reg <= term_a[63] ? (64'd0 - term_a) : term_a;
            ug_reg  <= term_g[31] ? (32'd0 - term_g) : term_g;
            neg_reg <= term_a[63] ^ term_g[31];
        end
        if (cmd.term_acc)
        begin
            sum_reg <= sum_sat;
        end
        if (cmd.finish)
        begin
            drive_reg  <= status.enabled ? drive : '0;
            frozen_reg <= status.enabled && !commit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            term_idx_reg <= '0;
        end
        else
        begin
            if (cmd.set_i)
            begin
                cnt_reg <= CNT_WIDTH'(RCP_STEPS - 1);
            end
            else if (cmd.set_d)
            begin
                cnt_reg <= CNT_WIDTH'(DIV_STEPS - 1);
            end
            else if (cmd.div_step || cmd.rcp_step)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.load)
            begin
                term_idx_reg <= '0;
            end
            else if (cmd.term_acc)
            begin
                term_idx_reg <= term_idx_reg + 1'b1;
            end
        end
    end

    // scan state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            last_run_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (status.enabled)
                begin
                    last_run_reg <= ts_reg;
                    prev_err_reg <= err_reg;
                    if (commit)
                    begin
                        integral_reg <= tent_reg;
                    end
                end
                else
                begin
                    integral_reg <= '0;
                    prev_err_reg <= '0;
                    last_run_reg <= '0;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.enabled   = (enable_reg > EnableHalf);
    assign status.dt_zero   = (dt_reg == '0);
    assign status.div_last  = (cnt_reg == '0);
    assign status.term_last = (term_idx_reg == TERM_LAST);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = drive_reg;
    assign m_tuser[0] = frozen_reg;

    // a disabled scan leaves a cleared integral
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !status.enabled) |=> (integral_reg == '0 && last_run_reg == '0))
    else $error("integral not cleared on disabled scan");

    // a frozen result sits on one of the limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frozen_reg) |-> (drive_reg == limit_hi_reg || drive_reg == limit_lo_reg))
    else $error("frozen drive not at a limit");

    // partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (rem_reg < dvs_reg))
    else $error("divider remainder out of range");

endmodule

[sim/pawc_checker.sv]
// ----------------------------------------------------------------------------
// pawc_checker
// Watches the scan, drive and register channels of the PID controller,
// predicts each drive value and frozen flag, and counts mismatches.
// ----------------------------------------------------------------------------
module pawc_checker
    import pawc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    output int           errors,
    output int           pending
);

    localparam int FB = 16;
    localparam int IW = 48;
    localparam longint IMAX = (64'sd1 <<< (IW - 1)) - 1;
    localparam longint IMIN = -IMAX - 1;
    localparam longint S64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [31:0] drive;
        logic        frozen;
    } drive_t;

    longint kp, ki, kd, lim_lo, lim_hi;
    int unsigned period;
    longint integ, prev_err;
    int unsigned last_run;
    drive_t drive_q[$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        if (b > 0 && a > S64MAX - b)
            return S64MAX;
        if (b < 0 && a < S64MIN - b)
            return S64MIN;
        return a + b;
    endfunction

    // (a * g) >> FB toward zero, saturated to 64 bits
    function automatic longint gain_mul(longint a, longint g);
        logic signed [127:0] p;
        logic [127:0] mag;
        logic neg;
        p = 128'(signed'(a)) * 128'(signed'(g));
        neg = p[127];
        mag = neg ? -p : p;
        mag = mag >> FB;
        if (mag >= (128'd1 << 63))
            return neg ? S64MIN : S64MAX;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    task automatic predict_scan(input logic [127:0] d);
        longint en, pv, sp, err, incr, tent, deriv, sum, drv;
        int unsigned now, dt;
        logic commit;
        drive_t r;
        en = longint'(signed'(d[31:0]));
        pv = longint'(signed'(d[63:32]));
        sp = longint'(signed'(d[95:64]));
        now = d[127:96];
        if (en <= (64'sd1 <<< (FB - 1)))
        begin
            integ = 0;
            prev_err = 0;
            last_run = 0;
            r.drive = '0;
            r.frozen = 1'b0;
            drive_q.push_back(r);
            return;
        end
        dt = (last_run == 0) ? period : now - last_run;
        last_run = now;
        err = clamp(sp - pv, -64'sd2147483648, 64'sd2147483647);
        incr = (err * longint'(dt)) / 1000;
        tent = clamp(add_sat(integ, incr), IMIN, IMAX);
        deriv = (dt == 0) ? 0 : clamp(((err - prev_err) * 1000) / longint'(dt),
                                       -64'sd2147483648, 64'sd2147483647);
        prev_err = err;
        sum = add_sat(gain_mul(err, kp), gain_mul(tent, ki));
        sum = add_sat(sum, gain_mul(deriv, kd));
        drv = sum;
        if (drv > lim_hi)
            drv = lim_hi;
        else if (drv < lim_lo)
            drv = lim_lo;
        commit = (sum <= lim_hi) && (sum >= lim_lo);
        if (commit)
            integ = tent;
        r.drive = drv[31:0];
        r.frozen = ~commit;
        drive_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_t e;
        if (!rst_n)
        begin
            kp = 0; ki = 0; kd = 0; lim_lo = 0; lim_hi = 6553600;
            period = 50; integ = 0; prev_err = 0; last_run = 0;
            drive_q.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_GAIN_P:   kp = longint'(signed'(cfg_data));
                    REG_GAIN_I:   ki = longint'(signed'(cfg_data));
                    REG_GAIN_D:   kd = longint'(signed'(cfg_data));
                    REG_LIMIT_LO: lim_lo = longint'(signed'(cfg_data));
                    REG_LIMIT_HI: lim_hi = longint'(signed'(cfg_data));
                    REG_PERIOD:   period = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (drive_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected drive beat %h/%b", m_tdata, m_tuser);
                    errors <= errors + 1;
                end
                else
                begin
                    e = drive_q.pop_front();
                    if (e.drive !== m_tdata || e.frozen !== m_tuser[0])
                    begin
                        if (errors < 10)
                            $display("drive mismatch: expected %h/%b got %h/%b",
                                     e.drive, e.frozen, m_tdata, m_tuser[0]);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_scan(s_tdata);
            pending <= drive_q.size();
        end
    end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives register writes and control scans into the PID controller under
// changing idle patterns and a long output stall; the checker judges beats.
// ----------------------------------------------------------------------------
module tb;
    import pawc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic [0:0]   m_tuser;
    int           errors;
    int           pending;
    int           tx_idle;
    int           rx_idle;
    int           hold_cycles;
    int           quiet;
    int unsigned  clock_ms;

    pid_anti_windup_controller_unit uut (.*);

    pawc_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stall, or a long counted hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending != 0 || s_tvalid)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic send_scan(input logic [31:0] en, input logic [31:0] pv,
                             input logic [31:0] sp, input logic [31:0] ts);
        while ($urandom_range(99) < tx_idle)
            @(negedge clk);
        s_tdata <= {ts, sp, pv, en};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_q(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($urandom_range(0, 400000)) - 32'd200000;
            2: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    task automatic rand_settings(input bit extreme);
        write_reg(REG_GAIN_P, extreme ? rand_q($urandom_range(0, 3))
                                      : 32'($urandom_range(0, 262144)) - 32'd131072);
        write_reg(REG_GAIN_I, extreme ? rand_q($urandom_range(0, 3))
                                      : 32'($urandom_range(0, 131072)) - 32'd65536);
        write_reg(REG_GAIN_D, extreme ? rand_q($urandom_range(0, 3))
                                      : 32'($urandom_range(0, 8192)) - 32'd4096);
        write_reg(REG_LIMIT_LO, extreme ? rand_q($urandom_range(0, 3))
                                        : -32'($urandom_range(0, 6553600)));
        write_reg(REG_LIMIT_HI, extreme ? rand_q($urandom_range(0, 3))
                                        : 32'($urandom_range(0, 6553600)));
        write_reg(REG_PERIOD, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                        : $urandom_range(1, 200));
    endtask

    // mostly enabled runs with advancing time, some disables and odd times
    task automatic random_scans(input int count);
        logic [31:0] en, ts;
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 8)
                en = $urandom_range(0, 32768);
            else if (k < 12)
                en = $urandom();
            else
                en = 32'($urandom_range(32769, 2000000));
            k = $urandom_range(99);
            if (k < 5)
                ts = 0;
            else if (k < 10)
                ts = $urandom();
            else
            begin
                clock_ms += $urandom_range(0, 120);
                ts = clock_ms;
            end
            send_scan(en, rand_q($urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 3)),
                      rand_q($urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 3)), ts);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        tx_idle = 0;
        rx_idle = 0;
        hold_cycles = 0;
        quiet = 0;
        clock_ms = 1000;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset settings, then field extremes and special cases
        send_scan(32'h0001_0000, 32'd0, 32'h0010_0000, 32'd100);
        send_scan(32'h0000_8000, 32'd5, 32'd6, 32'd200);
        send_scan(32'h0000_8001, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        send_scan(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        send_scan(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        write_reg(REG_GAIN_P, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_I, 32'h8000_0000);
        write_reg(REG_GAIN_D, 32'h7FFF_FFFF);
        write_reg(REG_LIMIT_LO, 32'h8000_0000);
        write_reg(REG_LIMIT_HI, 32'h7FFF_FFFF);
        write_reg(REG_PERIOD, 32'd65535);
        send_scan(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
        send_scan(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0010);
        send_scan(32'h0001_0000, 32'd1, 32'd2, 32'h0000_0010);
        send_scan(32'h0001_0000, 32'd3, 32'd0, 32'h0000_8000);
        drain();
        // zero period, inverted limits, and an unknown register index
        write_reg(REG_PERIOD, 32'd0);
        write_reg(REG_LIMIT_LO, 32'd6553600);
        write_reg(REG_LIMIT_HI, 32'hFFF0_0000);
        write_reg(cfg_reg_t'(3'd7), 32'hDEAD_BEEF);
        send_scan(32'h0000_0000, 32'd0, 32'd0, 32'd0);
        send_scan(32'h0001_0000, 32'h0001_0000, 32'h0005_0000, 32'd7);
        send_scan(32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'd7);
        send_scan(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'd9);
        drain();
        write_reg(REG_PERIOD, 32'd50);
        write_reg(REG_LIMIT_LO, 32'hFF9C_0000);
        write_reg(REG_LIMIT_HI, 32'h0064_0000);
        write_reg(REG_GAIN_P, 32'h0001_0000);
        write_reg(REG_GAIN_I, 32'h0000_8000);
        write_reg(REG_GAIN_D, 32'h0000_0100);
        send_scan(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'd10);
        send_scan(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'd60);
        send_scan(32'h0001_0000, 32'h0000_0000, 32'h0050_0000, 32'd110);
        drain();

        // random phases
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph < 4)
            begin
                tx_idle = 11;
                rx_idle = 80;
            end
            else if (ph < 8)
            begin
                tx_idle = 80;
                rx_idle = 11;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            rand_settings(ph % 3 == 2);
            if (ph == 9)
                hold_cycles <= 2000;
            random_scans(145);
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/pawc_pkg.sv
rtl/pawc_ctrl.sv
rtl/pawc_datapath.sv
rtl/pid_anti_windup_controller_unit.sv
sim/pawc_checker.sv
sim/tb.sv
